// File: rtl/atrdc_pkg.sv
// ----------------------------------------------------------------------------
// atrdc_pkg - shared constants for the AT response deframer/classifier
// Prefix text, type word, quote, event and status codes used by the line parser.
// ----------------------------------------------------------------------------
package atrdc_pkg;

  typedef logic [7:0] byte_t;

  localparam byte_t CHAR_CR    = 8'd13;
  localparam byte_t CHAR_LF    = 8'd10;
  localparam byte_t CHAR_QUOTE = 8'h22;
  localparam byte_t CHAR_COMMA = 8'h2C;

  localparam int NUM_PFX = 6;
  localparam int PFX_W   = 88;

  localparam int PFX_PAIR      = 0;
  localparam int PFX_CONNECT   = 1;
  localparam int PFX_BSIR      = 2;
  localparam int PFX_NOCARRIER = 3;
  localparam int PFX_HFI       = 4;
  localparam int PFX_OK        = 5;

  // prefixes left aligned, first character in the top byte
  localparam logic [PFX_W-1:0] PFX_TEXT [NUM_PFX] = '{
    {"PAIR ", 48'd0},
    {"CONNECT ", 24'd0},
    {"HF\"+BSIR:", 16'd0},
    "NO CARRIER ",
    {"HFI\"", 56'd0},
    {"OK", 72'd0}
  };
  localparam logic [3:0] PFX_LEN [NUM_PFX] = '{4'd5, 4'd8, 4'd9, 4'd11, 4'd4, 4'd2};

  localparam logic [71:0] TYPE_WORD = "callsetup";
  localparam logic [3:0]  TM_CALL   = 4'd4;
  localparam logic [3:0]  TM_SETUP  = 4'd9;
  localparam logic [3:0]  TM_DEAD   = 4'd15;

  localparam logic [1:0] QS_NONE  = 2'd0;
  localparam logic [1:0] QS_CALL  = 2'd1;
  localparam logic [1:0] QS_SETUP = 2'd2;

  localparam logic [2:0] EV_PAIRING = 3'd0;
  localparam logic [2:0] EV_LINK    = 3'd1;
  localparam logic [2:0] EV_SETUP   = 3'd2;
  localparam logic [2:0] EV_CALL    = 3'd3;
  localparam logic [2:0] EV_UNKNOWN = 3'd4;

  localparam logic [1:0] ST_UNKNOWN  = 2'd0;
  localparam logic [1:0] ST_GOOD     = 2'd1;
  localparam logic [1:0] ST_BAD      = 2'd2;

  function automatic byte_t pfx_char(input int k, input logic [3:0] pos);
    logic [PFX_W-1:0] s;
    s = PFX_TEXT[k];
    return s[PFX_W-1-8*pos -: 8];
  endfunction

  function automatic byte_t type_char(input logic [3:0] idx);
    byte_t c;
    c = 8'd0;
    if (idx < TM_SETUP) begin
      c = TYPE_WORD[71-8*idx -: 8];
    end
    return c;
  endfunction

endpackage

// File: rtl/at_response_deframer_classifier.sv
// ----------------------------------------------------------------------------
// at_response_deframer_classifier - AT response line deframer and classifier
// Splits CR/LF framed lines, streams payload, classifies frames on the fly.
// ----------------------------------------------------------------------------
// One received byte is taken per transaction and every byte yields exactly one
// result in the next cycle: the parse state and the prefix matchers advance
// together, so a new byte is accepted every clock while the result register
// is free or being drained. The result register decouples the two sides;
// pair/link/setup/call status always shows the state after the byte.
module at_response_deframer_classifier
  import atrdc_pkg::*;
#(
  parameter int MAX_LINE = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_payload_valid,
  output logic [7:0] out_payload_byte,
  output logic       out_frame_done,
  output logic       out_frame_kind,
  output logic [2:0] out_event_kind,
  output logic [2:0] out_first_digit,
  output logic       out_starts_ok,
  output logic [1:0] out_pair_status,
  output logic [1:0] out_link_status,
  output logic [7:0] out_setup_value,
  output logic [7:0] out_call_value
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_HDR   = 3'd1;
  localparam logic [2:0] PH_HDR2  = 3'd2;
  localparam logic [2:0] PH_TEXT  = 3'd3;
  localparam logic [2:0] PH_FOOT  = 3'd4;
  localparam logic [2:0] PH_FOOT2 = 3'd5;

  localparam logic [7:0] LINE_MAX = 8'(MAX_LINE);

  logic [2:0] phase_r, phase_nxt;
  logic       is_pkt_r, is_pkt_nxt;
  logic [7:0] len_r, len_nxt;
  logic [NUM_PFX-1:0] alive_r, alive_nxt;
  logic [3:0] tm_r, tm_nxt;
  logic [1:0] qs_r, qs_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic       vopen_r, vopen_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] pchar_r, pchar_nxt;
  logic [1:0] pair_r, pair_nxt;
  logic [1:0] link_r, link_nxt;
  logic [7:0] setup_r, setup_nxt;
  logic [7:0] call_r, call_nxt;

  logic       out_valid_r;
  logic       pv_r, pv_nxt;
  logic [7:0] pb_r, pb_nxt;
  logic       done_r, done_nxt;
  logic       kind_r, kind_nxt;
  logic [2:0] ev_r, ev_nxt;
  logic [2:0] fd_r, fd_nxt;
  logic       ok_r, ok_nxt;

  // append path results
  logic [7:0] ac;
  logic [7:0] lc;
  logic [NUM_PFX-1:0] alive_app;
  logic [3:0] tm_app;
  logic [1:0] qs_app;
  logic [7:0] acc_app;
  logic       vopen_app;
  logic [11:0] acc_mul;
  logic        do_append;
  logic [NUM_PFX-1:0] hit;

  logic accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ac = (phase_r == PH_TEXT && in_rx_byte == CHAR_CR) ? CHAR_LF : in_rx_byte;
    lc = (ac >= "A" && ac <= "Z") ? ac + 8'd32 : ac;

    alive_app = alive_r;
    for (int k = 0; k < NUM_PFX; k++) begin
      if (len_r < {4'd0, PFX_LEN[k]} && pfx_char(k, len_r[3:0]) != ac) begin
        alive_app[k] = 1'b0;
      end
    end

    tm_app = tm_r;
    qs_app = qs_r;
    if (len_r >= 8'd4) begin
      if (ac == CHAR_QUOTE) begin
        qs_app = (tm_r == TM_CALL) ? QS_CALL : (tm_r == TM_SETUP) ? QS_SETUP : QS_NONE;
      end
      if (tm_r < TM_SETUP && lc == type_char(tm_r)) begin
        tm_app = tm_r + 4'd1;
      end else begin
        tm_app = TM_DEAD;
      end
    end else if (ac == CHAR_QUOTE) begin
      qs_app = QS_NONE;
    end

    acc_mul   = {4'd0, acc_r} * 12'd10 + {4'd0, ac - 8'h30};
    acc_app   = acc_r;
    vopen_app = 1'b0;
    if (ac == CHAR_COMMA) begin
      acc_app   = 8'd0;
      vopen_app = 1'b1;
    end else if (vopen_r && ac >= "0" && ac <= "9") begin
      acc_app   = (acc_mul > 12'd255) ? 8'd255 : acc_mul[7:0];
      vopen_app = 1'b1;
    end

    for (int k = 0; k < NUM_PFX; k++) begin
      hit[k] = alive_r[k] && (len_r >= {4'd0, PFX_LEN[k]});
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    is_pkt_nxt = is_pkt_r;
    len_nxt = len_r;
    alive_nxt = alive_r;
    tm_nxt = tm_r;
    qs_nxt = qs_r;
    acc_nxt = acc_r;
    vopen_nxt = vopen_r;
    first_nxt = first_r;
    pchar_nxt = pchar_r;
    pair_nxt = pair_r;
    link_nxt = link_r;
    setup_nxt = setup_r;
    call_nxt = call_r;
    do_append = 1'b0;
    done_nxt = 1'b0;
    kind_nxt = 1'b0;
    ev_nxt = 3'd0;
    fd_nxt = 3'd0;
    ok_nxt = 1'b0;

    case (phase_r)
      PH_HDR: begin
        // start a fresh line
        len_nxt = 8'd0;
        alive_nxt = '1;
        tm_nxt = 4'd0;
        qs_nxt = QS_NONE;
        acc_nxt = 8'd0;
        vopen_nxt = 1'b0;
        first_nxt = 8'd0;
        pchar_nxt = 8'd0;
        if (in_rx_byte == CHAR_CR) begin
          is_pkt_nxt = 1'b1;
          phase_nxt = PH_HDR2;
        end else if (in_rx_byte == CHAR_LF) begin
          is_pkt_nxt = 1'b0;
          phase_nxt = PH_TEXT;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_HDR2: begin
        phase_nxt = (in_rx_byte == CHAR_LF) ? PH_TEXT : PH_IDLE;
      end
      PH_TEXT: begin
        if (in_rx_byte == CHAR_CR) begin
          if (len_r == 8'd0) begin
            phase_nxt = PH_HDR;
          end else if (is_pkt_r) begin
            do_append = 1'b1;
            phase_nxt = PH_FOOT;
          end else begin
            phase_nxt = PH_FOOT2;
          end
        end else if (in_rx_byte == CHAR_LF) begin
          phase_nxt = PH_IDLE;
        end else begin
          do_append = 1'b1;
        end
      end
      PH_FOOT, PH_FOOT2: begin
        if (in_rx_byte == CHAR_LF) begin
          if (phase_r == PH_FOOT) begin
            phase_nxt = PH_FOOT2;
          end else begin
            phase_nxt = PH_IDLE;
            done_nxt = 1'b1;
            kind_nxt = is_pkt_r;
            fd_nxt = (first_r >= "0" && first_r <= "6") ? 3'(first_r - 8'h30) : 3'd7;
            ok_nxt = hit[PFX_OK];
            // classify: first matching prefix wins
            if (hit[PFX_PAIR]) begin
              pair_nxt = (pchar_r >= "1" && pchar_r <= "9") ? ST_BAD : ST_GOOD;
              ev_nxt = EV_PAIRING;
            end else if (hit[PFX_CONNECT] || hit[PFX_BSIR]) begin
              link_nxt = ST_GOOD;
              ev_nxt = EV_LINK;
            end else if (hit[PFX_NOCARRIER]) begin
              link_nxt = ST_BAD;
              ev_nxt = EV_LINK;
            end else if (hit[PFX_HFI] && qs_r == QS_SETUP) begin
              setup_nxt = acc_r;
              ev_nxt = EV_SETUP;
            end else if (hit[PFX_HFI] && qs_r == QS_CALL) begin
              call_nxt = acc_r;
              ev_nxt = EV_CALL;
            end else begin
              ev_nxt = EV_UNKNOWN;
            end
          end
        end else begin
          do_append = 1'b1;
          phase_nxt = PH_TEXT;
        end
      end
      default: begin
        phase_nxt = (in_rx_byte == CHAR_CR) ? PH_HDR : PH_IDLE;
      end
    endcase

    if (do_append) begin
      alive_nxt = alive_app;
      tm_nxt = tm_app;
      qs_nxt = qs_app;
      acc_nxt = acc_app;
      vopen_nxt = vopen_app;
      if (len_r == 8'd0) begin
        first_nxt = ac;
      end
      if (len_r == 8'd5) begin
        pchar_nxt = ac;
      end
      if (len_r < LINE_MAX) begin
        len_nxt = len_r + 8'd1;
      end
    end

    pv_nxt = do_append;
    pb_nxt = do_append ? ac : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      is_pkt_r <= 1'b0;
      len_r <= 8'd0;
      alive_r <= '1;
      tm_r <= 4'd0;
      qs_r <= QS_NONE;
      acc_r <= 8'd0;
      vopen_r <= 1'b0;
      first_r <= 8'd0;
      pchar_r <= 8'd0;
      pair_r <= ST_UNKNOWN;
      link_r <= ST_UNKNOWN;
      setup_r <= 8'd0;
      call_r <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        is_pkt_r <= is_pkt_nxt;
        len_r <= len_nxt;
        alive_r <= alive_nxt;
        tm_r <= tm_nxt;
        qs_r <= qs_nxt;
        acc_r <= acc_nxt;
        vopen_r <= vopen_nxt;
        first_r <= first_nxt;
        pchar_r <= pchar_nxt;
        pair_r <= pair_nxt;
        link_r <= link_nxt;
        setup_r <= setup_nxt;
        call_r <= call_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      pv_r <= pv_nxt;
      pb_r <= pb_nxt;
      done_r <= done_nxt;
      kind_r <= kind_nxt;
      ev_r <= ev_nxt;
      fd_r <= fd_nxt;
      ok_r <= ok_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_valid = pv_r;
  assign out_payload_byte  = pb_r;
  assign out_frame_done    = done_r;
  assign out_frame_kind    = kind_r;
  assign out_event_kind    = ev_r;
  assign out_first_digit   = fd_r;
  assign out_starts_ok     = ok_r;
  assign out_pair_status   = pair_r;
  assign out_link_status   = link_r;
  assign out_setup_value   = setup_r;
  assign out_call_value    = call_r;

  a_done_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> !pv_r)
    else $error("frame end carries a payload byte");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LINE_MAX)
    else $error("line length above limit");

  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> ev_r <= EV_UNKNOWN)
    else $error("event class out of range");

  a_done_from_footer: assert property (@(posedge clk) disable iff (!rst_n)
    accept && done_nxt |=> phase_r == PH_IDLE && $past(phase_r) == PH_FOOT2)
    else $error("frame end outside the footer");

endmodule
